// ===== rtl/char_lcd_nibble_sequencer_core_macros.svh =====
// Assertion helpers shared by the sequencer modules.
// Each expects clk_i and rst_ni in the enclosing module.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CLNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CLNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLNS_ASSERT_IMP(lbl, ante, cons)
`define CLNS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lcdns_pkg.sv =====
`timescale 1ns / 1ps
package lcdns_pkg;

  // Operation codes; 6 and 7 are unused and produce nothing
  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_COMMAND = 3'd1,
    OP_CHAR    = 3'd2,
    OP_NUMBER  = 3'd3,
    OP_CURSOR  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  // Pause codes handed to the pin driver
  typedef enum logic [2:0] {
    WAIT_PULSE   = 3'd0,
    WAIT_CMD     = 3'd1,
    WAIT_CLEAR   = 3'd2,
    WAIT_5MS     = 3'd3,
    WAIT_1MS     = 3'd4,
    WAIT_POWERUP = 3'd5
  } wait_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FUNC_SET = 3'd0,
    REG_CLEAR    = 3'd1,
    REG_ENTRY    = 3'd2,
    REG_DISP_ON  = 3'd3,
    REG_DDRAM    = 3'd4,
    REG_ROW1_OFS = 3'd5,
    REG_ROW2_OFS = 3'd6
  } reg_e;

  // Where the current nibble comes from
  typedef enum logic [1:0] {
    SRC_INIT  = 2'd0,
    SRC_BYTE  = 2'd1,
    SRC_SIGN  = 2'd2,
    SRC_DIGIT = 2'd3
  } src_e;

  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [3:0] DIGIT_HI      = 4'h3;
  localparam logic [7:0] DISP_OFF_CMD  = 8'h08;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] FOURBIT_NIB   = 4'h2;
  localparam logic [3:0] INIT_LAST    = 4'd14;
  localparam logic [3:0] INIT_BYTE0   = 4'd5;
  localparam logic [2:0] TOP_DIGIT    = 3'd4;
  localparam logic [7:0] ROW_SECOND   = 8'd2;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       emit;
    src_e       src;
    logic [3:0] step;
    logic       half;
    logic [2:0] pos;
    logic       last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic neg;
    logic dig_zero;
  } stat_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } dec_step_t;

  function automatic logic [16:0] pow10(logic [2:0] pos);
    logic [16:0] r;
    unique case (pos)
      3'd0:    r = 17'd1;
      3'd1:    r = 17'd10;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd1000;
      3'd4:    r = 17'd10000;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

  // One decimal digit at position pos and what remains below it
  function automatic dec_step_t dec_step(logic [15:0] mag, logic [2:0] pos);
    dec_step_t   r;
    logic [16:0] pw;
    logic [16:0] prod;
    pw      = pow10(pos);
    r.digit = '0;
    r.rem   = mag;
    for (int d = 1; d < 10; d++) begin
      prod = 17'(d) * pw;
      if ({1'b0, mag} >= prod) begin
        r.digit = 4'(d);
        r.rem   = 16'({1'b0, mag} - prod);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_sequencer_core.sv =====
`timescale 1ns / 1ps
// Character LCD nibble sequencer, 4-bit pin interface.
// Input stream: one operation per item (opcode on tuser; byte, number, row
// and column on tdata). Output stream: one nibble transfer or pure wait per
// item, with register select on tuser and tlast on the final item of an
// operation. Register writes go through cfg_we_i/cfg_addr_i/cfg_wdata_i
// and take effect at once; write them only while the block is idle.
// Throughput: a controller state machine steps at most one output item per
// cycle while the output register is free, and waits while it is held. An
// operation is taken in the idle state; then init sends fifteen items and
// command/character/cursor/clear two each. A number first checks the sign
// (sending the minus sign when negative), then per decimal position either
// skips a leading zero or sends its two nibbles. Digits come from one shared
// digit-extraction unit, one decimal position per step.
// Reset loads the register defaults and empties the output register.
// If the receiver stalls, the held output item stays put and the sequencer
// waits; the next operation is taken as soon as the last result of the
// previous one sits in the output register.
module char_lcd_nibble_sequencer_core #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_value[7:0], number_value[23:8], row_number[31:24], column_number[39:32]
  input  logic [39:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // strobe_res[0], nibble[4:1], wait_code[7:5]
  output logic [7:0]  m_axis_tdata,
  // register_select[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import lcdns_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic       strobe, rs;
  logic [3:0] nib;
  logic [2:0] wcode;

  lcdns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lcdns_dpath #(
    .COLUMNS (COLUMNS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_opcode_i  (s_axis_tuser),
    .in_byte_i    (s_axis_tdata[7:0]),
    .in_number_i  (s_axis_tdata[23:8]),
    .in_row_i     (s_axis_tdata[31:24]),
    .in_col_i     (s_axis_tdata[39:32]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_strobe_o (strobe),
    .out_rs_o     (rs),
    .out_nibble_o (nib),
    .out_wait_o   (wcode),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {wcode, nib, strobe};
  assign m_axis_tuser = rs;

endmodule

// ===== rtl/lcdns_ctrl.sv =====
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_core_macros.svh"
module lcdns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        in_opcode_i,
  input  lcdns_pkg::stat_t  stat_i,
  output lcdns_pkg::cmd_t   cmd_o
);
  import lcdns_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_BYTE,
    ST_SIGN,
    ST_NUM
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       half_q, half_d;
  logic [2:0] pos_q, pos_d;
  logic       started_q, started_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      half_q    <= 1'b0;
      pos_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      half_q    <= half_d;
      pos_q     <= pos_d;
      started_q <= started_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    half_d        = half_q;
    pos_d         = pos_q;
    started_d     = started_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.src     = SRC_INIT;
    cmd_o.step    = step_q;
    cmd_o.half    = half_q;
    cmd_o.pos     = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          half_d        = 1'b0;
          case (op_e'(in_opcode_i)) inside
            OP_INIT: begin
              state_d = ST_INIT;
              step_d  = '0;
            end
            OP_COMMAND, OP_CHAR, OP_CURSOR, OP_CLEAR: state_d = ST_BYTE;
            OP_NUMBER: begin
              state_d   = ST_SIGN;
              pos_d     = TOP_DIGIT;
              started_d = 1'b0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.src = SRC_INIT;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (step_q == INIT_LAST) begin
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      ST_BYTE: begin
        cmd_o.src = SRC_BYTE;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (half_q) begin
            cmd_o.last = 1'b1;
            half_d     = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            half_d = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        cmd_o.src = SRC_SIGN;
        if (!stat_i.neg) begin
          state_d = ST_NUM;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          half_d     = !half_q;
          if (half_q) state_d = ST_NUM;
        end
      end
      ST_NUM: begin
        cmd_o.src = SRC_DIGIT;
        // leading zeros are skipped, the units digit always goes out
        if (!half_q && stat_i.dig_zero && !started_q && pos_q != '0) begin
          pos_d = pos_q - 3'd1;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!half_q) begin
            half_d    = 1'b1;
            started_d = 1'b1;
          end else begin
            half_d = 1'b0;
            if (pos_q == '0) begin
              cmd_o.last = 1'b1;
              state_d    = ST_IDLE;
            end else begin
              pos_d = pos_q - 3'd1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `CLNS_ASSERT_IMP(a_idle_no_emit, state_q == ST_IDLE, !cmd_o.emit)
  `CLNS_ASSERT_IMP(a_emit_slot_free, cmd_o.emit, stat_i.out_free)
  `CLNS_ASSERT_NXT(a_last_to_idle, cmd_o.emit && cmd_o.last, state_q == ST_IDLE)
  `CLNS_ASSERT_IMP(a_pos_range, state_q == ST_NUM, pos_q <= TOP_DIGIT)

endmodule

// ===== rtl/lcdns_dpath.sv =====
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_core_macros.svh"
module lcdns_dpath #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic [2:0]         in_opcode_i,
  input  logic [7:0]         in_byte_i,
  input  logic signed [15:0] in_number_i,
  input  logic [7:0]         in_row_i,
  input  logic [7:0]         in_col_i,
  input  lcdns_pkg::cmd_t    cmd_i,
  output lcdns_pkg::stat_t   stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_strobe_o,
  output logic               out_rs_o,
  output logic [3:0]         out_nibble_o,
  output logic [2:0]         out_wait_o,
  output logic               out_last_o
);
  import lcdns_pkg::*;

  localparam logic [7:0] ColMax = 8'(COLUMNS);

  // Configuration registers
  logic [7:0] func_set_q, clear_q, entry_q, disp_on_q, ddram_q;
  logic [6:0] row1_ofs_q, row2_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_set_q <= 8'h28;
      clear_q    <= 8'h01;
      entry_q    <= 8'h06;
      disp_on_q  <= 8'h0C;
      ddram_q    <= 8'h80;
      row1_ofs_q <= 7'd0;
      row2_ofs_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_FUNC_SET: func_set_q <= cfg_wdata_i;
        REG_CLEAR:    clear_q    <= cfg_wdata_i;
        REG_ENTRY:    entry_q    <= cfg_wdata_i;
        REG_DISP_ON:  disp_on_q  <= cfg_wdata_i;
        REG_DDRAM:    ddram_q    <= cfg_wdata_i;
        REG_ROW1_OFS: row1_ofs_q <= cfg_wdata_i[6:0];
        REG_ROW2_OFS: row2_ofs_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Cursor address: clamped column plus row start
  logic [7:0] col_c, addr;
  always_comb begin
    if (in_col_i == 8'd0)      col_c = 8'd1;
    else if (in_col_i > ColMax) col_c = ColMax;
    else                       col_c = in_col_i;
    addr = ddram_q + {1'b0, (in_row_i == ROW_SECOND) ? row2_ofs_q : row1_ofs_q}
         + (col_c - 8'd1);
  end

  // Operand capture for single-byte operations and numbers
  logic [7:0]  byte_q, byte_d;
  logic        byte_rs_q, byte_rs_d;
  wait_e       byte_wait_q, byte_wait_d;
  logic        neg_q;
  logic [15:0] mag_q;
  dec_step_t   dec;

  always_comb begin
    byte_d      = clear_q;
    byte_rs_d   = 1'b0;
    byte_wait_d = WAIT_CMD;
    case (op_e'(in_opcode_i))
      OP_COMMAND: byte_d = in_byte_i;
      OP_CHAR: begin
        byte_d    = in_byte_i;
        byte_rs_d = 1'b1;
      end
      OP_CURSOR: byte_d = addr;
      default:   byte_wait_d = WAIT_CLEAR;
    endcase
  end

  assign dec = dec_step(mag_q, cmd_i.pos);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q      <= byte_d;
      byte_rs_q   <= byte_rs_d;
      byte_wait_q <= byte_wait_d;
      neg_q       <= in_number_i[15];
      mag_q       <= in_number_i[15] ? 16'(-in_number_i) : 16'(in_number_i);
    end else if (cmd_i.emit && cmd_i.src == SRC_DIGIT && cmd_i.half) begin
      mag_q <= dec.rem;
    end
  end

  // Init sequence byte list
  logic [3:0] init_k;
  logic [7:0] init_byte;
  wait_e      init_lo_wait;
  assign init_k = cmd_i.step - INIT_BYTE0;
  always_comb begin
    init_lo_wait = WAIT_CMD;
    case (init_k[3:1])
      3'd0:    init_byte = func_set_q;
      3'd1:    init_byte = DISP_OFF_CMD;
      3'd2: begin
        init_byte    = clear_q;
        init_lo_wait = WAIT_CLEAR;
      end
      3'd3:    init_byte = entry_q;
      default: init_byte = disp_on_q;
    endcase
  end

  // Build the next nibble item
  logic  nx_strobe, nx_rs;
  logic [3:0] nx_nib;
  wait_e nx_wait;
  always_comb begin
    nx_strobe = 1'b1;
    nx_rs     = 1'b0;
    nx_nib    = '0;
    nx_wait   = WAIT_PULSE;
    case (cmd_i.src)
      SRC_INIT: begin
        if (cmd_i.step == 4'd0) begin
          nx_strobe = 1'b0;
          nx_wait   = WAIT_POWERUP;
        end else if (cmd_i.step == 4'd1) begin
          nx_nib  = WAKE_NIBBLE;
          nx_wait = WAIT_5MS;
        end else if (cmd_i.step < 4'd4) begin
          nx_nib  = WAKE_NIBBLE;
          nx_wait = WAIT_1MS;
        end else if (cmd_i.step == 4'd4) begin
          nx_nib  = FOURBIT_NIB;
          nx_wait = WAIT_1MS;
        end else begin
          nx_nib  = init_k[0] ? init_byte[3:0] : init_byte[7:4];
          nx_wait = init_k[0] ? init_lo_wait : WAIT_PULSE;
        end
      end
      SRC_BYTE: begin
        nx_rs   = byte_rs_q;
        nx_nib  = cmd_i.half ? byte_q[3:0] : byte_q[7:4];
        nx_wait = cmd_i.half ? byte_wait_q : WAIT_PULSE;
      end
      SRC_SIGN: begin
        nx_rs   = 1'b1;
        nx_nib  = cmd_i.half ? CH_MINUS[3:0] : CH_MINUS[7:4];
        nx_wait = cmd_i.half ? WAIT_CMD : WAIT_PULSE;
      end
      default: begin
        nx_rs   = 1'b1;
        nx_nib  = cmd_i.half ? dec.digit : DIGIT_HI;
        nx_wait = cmd_i.half ? WAIT_CMD : WAIT_PULSE;
      end
    endcase
  end

  // Output register
  logic       out_valid_q;
  logic       out_strobe_q, out_rs_q, out_last_q;
  logic [3:0] out_nib_q;
  wait_e      out_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_strobe_q <= nx_strobe;
      out_rs_q     <= nx_rs;
      out_nib_q    <= nx_nib;
      out_wait_q   <= nx_wait;
      out_last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_strobe_o    = out_strobe_q;
  assign out_rs_o        = out_rs_q;
  assign out_nibble_o    = out_nib_q;
  assign out_wait_o      = out_wait_q;
  assign out_last_o      = out_last_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.neg      = neg_q;
  assign stat_o.dig_zero = (dec.digit == 4'd0);

  `CLNS_ASSERT_IMP(a_no_overwrite, out_valid_q && !out_ready_i, !cmd_i.emit)
  `CLNS_ASSERT_NXT(a_units_clear,
    cmd_i.emit && cmd_i.src == SRC_DIGIT && cmd_i.half && cmd_i.pos == 3'd0,
    mag_q == 16'd0)
  `CLNS_ASSERT_NXT(a_drain, out_valid_q && out_ready_i && !cmd_i.emit, !out_valid_q)

endmodule

// ===== tb/tb_char_lcd_nibble_sequencer_core.sv =====
`timescale 1ns / 1ps
module tb_char_lcd_nibble_sequencer_core;
  import lcdns_pkg::*;

  localparam int unsigned COLUMNS     = 16;
  localparam int          STALL_LIMIT = 1000;
  localparam int          SETTLE_CYC  = 20;
  localparam int          PHASE_OPS   = 47;
  localparam int          NUM_PHASES  = 6;
  localparam int          RST_CYC     = 6;

  // Register index past the end of the list; the write must be dropped
  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  // Opcodes that produce nothing
  localparam logic [2:0]  OP_NONE6    = 3'd6;
  localparam logic [2:0]  OP_NONE7    = 3'd7;

  localparam logic [7:0]  CHR_MINUS   = 8'h2D;
  localparam logic [7:0]  CHR_ZERO    = 8'h30;
  localparam logic [7:0]  DISPLAY_OFF = 8'h08;
  localparam logic [3:0]  NIB_WAKE    = 4'h3;
  localparam logic [3:0]  NIB_4BIT    = 4'h2;
  localparam logic [7:0]  SECOND_ROW  = 8'd2;

  typedef enum int {CFG_ZERO, CFG_ONES, CFG_RAND} cfg_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY3, RX_HOLD} rx_mode_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  byte_val;
    logic [15:0] num;
    logic [7:0]  row;
    logic [7:0]  col;
  } lcd_op_t;

  typedef struct packed {
    logic       strobe;
    logic       rs;
    logic [3:0] nib;
    logic [2:0] wcode;
    logic       last;
  } pin_xfer_t;

  // One row of the directed table; typed rows carry the byte they must send
  typedef struct packed {
    lcd_op_t    op;
    logic       typed;
    logic [7:0] exp_byte;
    logic       exp_rs;
    logic [2:0] exp_wait;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_addr_i    = '0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow copy of the register file
  logic [7:0]  fs_cmd;
  logic [7:0]  clr_cmd;
  logic [7:0]  entry_cmd;
  logic [7:0]  dispon_cmd;
  logic [7:0]  ddram_base;
  logic [6:0]  row1_ofs;
  logic [6:0]  row2_ofs;

  pin_xfer_t   pin_xfer_q[$];
  dir_row_t    dir_rows[$];
  int          error_cnt  = 0;
  int          burst_left = 0;
  int          idle_cyc   = 0;
  int          rx_cyc     = 0;
  int          rx_hold    = 0;
  rx_mode_e    rx_mode    = RX_OPEN;
  logic        rx_next;
  pin_xfer_t   got_xfer;
  pin_xfer_t   want_xfer;

  char_lcd_nibble_sequencer_core #(
    .COLUMNS(COLUMNS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic void push_xfer(logic strobe, logic rs, logic [3:0] nib,
                                    logic [2:0] wcode);
    pin_xfer_t t;
    t.strobe = strobe;
    t.rs     = rs;
    t.nib    = nib;
    t.wcode  = wcode;
    t.last   = 1'b0;
    pin_xfer_q.push_back(t);
  endfunction

  // High nibble first with a bare pulse, low nibble carries the pause
  function automatic void push_byte(logic [7:0] b, logic rs, logic [2:0] wcode);
    push_xfer(1'b1, rs, b[7:4], WAIT_PULSE);
    push_xfer(1'b1, rs, b[3:0], wcode);
  endfunction

  function automatic void mark_last();
    pin_xfer_t t;
    t      = pin_xfer_q.pop_back();
    t.last = 1'b1;
    pin_xfer_q.push_back(t);
  endfunction

  // Expands one operation into the nibble transfers it must produce
  function automatic void expand_lcd_op(lcd_op_t it);
    int         n0;
    int         mag;
    int         ndig;
    int         digs[5];
    int         k;
    int         colc;
    logic [7:0] addr;
    n0 = pin_xfer_q.size();
    case (it.op)
      OP_INIT: begin
        push_xfer(1'b0, 1'b0, 4'h0, WAIT_POWERUP);
        push_xfer(1'b1, 1'b0, NIB_WAKE, WAIT_5MS);
        push_xfer(1'b1, 1'b0, NIB_WAKE, WAIT_1MS);
        push_xfer(1'b1, 1'b0, NIB_WAKE, WAIT_1MS);
        push_xfer(1'b1, 1'b0, NIB_4BIT, WAIT_1MS);
        push_byte(fs_cmd, 1'b0, WAIT_CMD);
        push_byte(DISPLAY_OFF, 1'b0, WAIT_CMD);
        push_byte(clr_cmd, 1'b0, WAIT_CLEAR);
        push_byte(entry_cmd, 1'b0, WAIT_CMD);
        push_byte(dispon_cmd, 1'b0, WAIT_CMD);
      end
      OP_COMMAND: push_byte(it.byte_val, 1'b0, WAIT_CMD);
      OP_CHAR:    push_byte(it.byte_val, 1'b1, WAIT_CMD);
      OP_NUMBER: begin
        if (it.num[15]) begin
          mag = 32'h10000 - it.num;
          push_byte(CHR_MINUS, 1'b1, WAIT_CMD);
        end else begin
          mag = it.num;
        end
        if (mag == 0) begin
          push_byte(CHR_ZERO, 1'b1, WAIT_CMD);
        end else begin
          ndig = 0;
          while (mag > 0) begin
            digs[ndig] = mag % 10;
            mag        = mag / 10;
            ndig++;
          end
          for (k = ndig - 1; k >= 0; k--) begin
            push_byte(CHR_ZERO + 8'(digs[k]), 1'b1, WAIT_CMD);
          end
        end
      end
      OP_CURSOR: begin
        colc = it.col;
        if (colc < 1) colc = 1;
        if (colc > COLUMNS) colc = COLUMNS;
        // address sum wraps at 8 bits
        addr = ddram_base + ((it.row == SECOND_ROW) ? {1'b0, row2_ofs} : {1'b0, row1_ofs})
               + 8'(colc - 1);
        push_byte(addr, 1'b0, WAIT_CMD);
      end
      OP_CLEAR: push_byte(clr_cmd, 1'b0, WAIT_CLEAR);
      default: ;
    endcase
    if (pin_xfer_q.size() > n0) mark_last();
  endfunction

  function automatic void add_row(logic [2:0] op, logic [7:0] b, logic [15:0] num,
                                  logic [7:0] row, logic [7:0] col, logic typed,
                                  logic [7:0] eb, logic ers, logic [2:0] ew);
    dir_row_t r;
    r.op.op       = op;
    r.op.byte_val = b;
    r.op.num      = num;
    r.op.row      = row;
    r.op.col      = col;
    r.typed       = typed;
    r.exp_byte    = eb;
    r.exp_rs      = ers;
    r.exp_wait    = ew;
    dir_rows.push_back(r);
  endfunction

  function automatic lcd_op_t rand_lcd_op();
    lcd_op_t     it;
    int unsigned pick;
    logic [15:0] p10;
    it.byte_val = 8'($urandom);
    it.num      = 16'($urandom);
    it.row      = 8'($urandom);
    it.col      = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8)       it.op = OP_INIT;
    else if (pick < 22) it.op = OP_COMMAND;
    else if (pick < 36) it.op = OP_CHAR;
    else if (pick < 62) it.op = OP_NUMBER;
    else if (pick < 82) it.op = OP_CURSOR;
    else if (pick < 92) it.op = OP_CLEAR;
    else                it.op = $urandom_range(0, 1) ? OP_NONE6 : OP_NONE7;
    // numbers: small values, decade edges and the two extremes
    case ($urandom_range(0, 7))
      0: it.num = 16'($urandom_range(0, 20));
      1: it.num = -16'($urandom_range(1, 20));
      2: begin
        case ($urandom_range(0, 4))
          0:       p10 = 16'd1;
          1:       p10 = 16'd10;
          2:       p10 = 16'd100;
          3:       p10 = 16'd1000;
          default: p10 = 16'd10000;
        endcase
        it.num = p10 + 16'($urandom_range(0, 2)) - 16'd1;
        if ($urandom_range(0, 1)) it.num = -it.num;
      end
      3: it.num = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: ;
    endcase
    if ($urandom_range(0, 1)) it.row = SECOND_ROW;
    if ($urandom_range(0, 3) != 0) it.col = 8'($urandom_range(0, COLUMNS + 4));
    return it;
  endfunction

  // Bursts of items with random gaps between them
  task automatic send_lcd_op(input lcd_op_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {it.col, it.row, it.num, it.byte_val};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_xfers();
    while (pin_xfer_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Writes every index, the unused one included
  task automatic write_lcd_regs(input cfg_kind_e kind);
    logic [7:0] val;
    logic [2:0] ra;
    for (int idx = 0; idx <= int'(REG_UNUSED); idx++) begin
      ra = 3'(idx);
      case (kind)
        CFG_ZERO: val = 8'h00;
        CFG_ONES: val = 8'hFF;
        default:  val = 8'($urandom);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= ra;
      cfg_wdata_i <= val;
      case (ra)
        REG_FUNC_SET: fs_cmd     = val;
        REG_CLEAR:    clr_cmd    = val;
        REG_ENTRY:    entry_cmd  = val;
        REG_DISP_ON:  dispon_cmd = val;
        REG_DDRAM:    ddram_base = val;
        REG_ROW1_OFS: row1_ofs   = val[6:0];
        REG_ROW2_OFS: row2_ofs   = val[6:0];
        default: ;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic void check_field(string fname, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      error_cnt++;
    end
  endfunction

  // Output checker, receiver stall pattern and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_xfer.strobe = m_axis_tdata[0];
      got_xfer.nib    = m_axis_tdata[4:1];
      got_xfer.wcode  = m_axis_tdata[7:5];
      got_xfer.rs     = m_axis_tuser[0];
      got_xfer.last   = m_axis_tlast;
      if (pin_xfer_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %b", $time, got_xfer);
        error_cnt++;
      end else begin
        want_xfer = pin_xfer_q.pop_front();
        check_field("strobe", 4'(want_xfer.strobe), 4'(got_xfer.strobe));
        check_field("rs", 4'(want_xfer.rs), 4'(got_xfer.rs));
        check_field("nibble", want_xfer.nib, got_xfer.nib);
        check_field("wait_code", 4'(want_xfer.wcode), 4'(got_xfer.wcode));
        check_field("last", 4'(want_xfer.last), 4'(got_xfer.last));
      end
    end

    rx_cyc++;
    if (rx_cyc % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   rx_next = 1'b1;
      RX_COIN:   rx_next = ($urandom_range(0, 2) != 0);
      RX_EVERY3: rx_next = (rx_cyc % 3 != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          rx_next = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_hold = $urandom_range(1, 12);
          rx_next = 1'b0;
        end else begin
          rx_next = 1'b1;
        end
      end
    endcase
    m_axis_tready <= rx_next;

    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
    end
    if (idle_cyc >= STALL_LIMIT) begin
      $display("char_lcd_nibble_sequencer_core regression: fail");
      $finish;
    end
  end

  initial begin
    lcd_op_t it;
    int      cnt;
    fs_cmd     = 8'h28;
    clr_cmd    = 8'h01;
    entry_cmd  = 8'h06;
    dispon_cmd = 8'h0C;
    ddram_base = 8'h80;
    row1_ofs   = 7'd0;
    row2_ofs   = 7'd64;

    // Directed table, run on reset register values
    add_row(OP_INIT,    8'h00, 16'h0000, 8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_COMMAND, 8'h00, 16'h0000, 8'd0,   8'd0,   1'b1, 8'h00, 1'b0, WAIT_CMD);
    add_row(OP_COMMAND, 8'hFF, 16'h0000, 8'd0,   8'd0,   1'b1, 8'hFF, 1'b0, WAIT_CMD);
    // a clear sent as a raw command keeps the plain command pause
    add_row(OP_COMMAND, 8'h01, 16'h0000, 8'd0,   8'd0,   1'b1, 8'h01, 1'b0, WAIT_CMD);
    add_row(OP_CHAR,    8'h00, 16'h0000, 8'd0,   8'd0,   1'b1, 8'h00, 1'b1, WAIT_CMD);
    add_row(OP_CHAR,    8'hFF, 16'h0000, 8'd0,   8'd0,   1'b1, 8'hFF, 1'b1, WAIT_CMD);
    add_row(OP_CLEAR,   8'h00, 16'h0000, 8'd0,   8'd0,   1'b1, 8'h01, 1'b0, WAIT_CLEAR);
    // zero prints a single digit
    add_row(OP_NUMBER,  8'h00, 16'h0000, 8'd0,   8'd0,   1'b1, 8'h30, 1'b1, WAIT_CMD);
    add_row(OP_NUMBER,  8'h00, 16'h7FFF, 8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    // most negative value prints all five digits
    add_row(OP_NUMBER,  8'h00, 16'h8000, 8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NUMBER,  8'h00, 16'hFFFF, 8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NUMBER,  8'h00, 16'd1,    8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NUMBER,  8'h00, 16'd9,    8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NUMBER,  8'h00, 16'd10,   8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NUMBER,  8'h00, 16'd10000, 8'd0,  8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NUMBER,  8'h00, 16'hFFF6, 8'd0,   8'd0,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    // column clamps, row other than two goes to row one
    add_row(OP_CURSOR,  8'h00, 16'h0000, 8'd0,   8'd0,   1'b1, 8'h80, 1'b0, WAIT_CMD);
    add_row(OP_CURSOR,  8'h00, 16'h0000, 8'd2,   8'd255, 1'b1, 8'hCF, 1'b0, WAIT_CMD);
    add_row(OP_CURSOR,  8'h00, 16'h0000, 8'd255, 8'd16,  1'b1, 8'h8F, 1'b0, WAIT_CMD);
    add_row(OP_CURSOR,  8'h00, 16'h0000, 8'd2,   8'd1,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_CURSOR,  8'h00, 16'h0000, 8'd3,   8'd17,  1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NONE6,   8'hA5, 16'h1234, 8'd2,   8'd5,   1'b0, 8'h00, 1'b0, WAIT_PULSE);
    add_row(OP_NONE7,   8'h5A, 16'h4321, 8'd1,   8'd9,   1'b0, 8'h00, 1'b0, WAIT_PULSE);

    repeat (RST_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_lcd_op(dir_rows[i].op);
      if (dir_rows[i].typed) begin
        push_byte(dir_rows[i].exp_byte, dir_rows[i].exp_rs, dir_rows[i].exp_wait);
        mark_last();
      end else begin
        expand_lcd_op(dir_rows[i].op);
      end
    end

    // Random phases; registers change only while the block is idle
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        s_axis_tvalid <= 1'b0;
        drain_xfers();
        write_lcd_regs((phase == 1) ? CFG_ZERO : (phase == 2) ? CFG_ONES : CFG_RAND);
        burst_left = 0;
      end
      cnt = 0;
      while (cnt < PHASE_OPS) begin
        it = rand_lcd_op();
        send_lcd_op(it);
        expand_lcd_op(it);
        if (it.op <= OP_CLEAR) cnt++;
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_xfers();
    if (error_cnt == 0) begin
      $display("char_lcd_nibble_sequencer_core regression: pass");
    end else begin
      $display("char_lcd_nibble_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
